FILE: hdl/bcpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the B-spline derivative control point unit.
// No dependencies; used by the top level and its checker.
package bcpd_pkg;

    localparam int NUM_LANES   = 4;
    localparam int COORD_W     = 32;
    localparam int IN_TDATA_W  = 168;   // knot_index, knot_value, coord_0..3
    localparam int OUT_TDATA_W = 136;   // deriv_0..3, out_index
    localparam int KIDX_W      = 9;     // point counter plus order - 1 reaches 270

    // Input item kinds (s_axis_tuser)
    localparam logic CMD_KNOT  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    // Result status codes (m_axis_tuser)
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO_SPAN = 2'd1;
    localparam logic [1:0] STATUS_SAT       = 2'd2;

    // Configuration register indexes
    localparam logic REG_SPLINE_ORDER = 1'b0;
    localparam logic REG_COORD_COUNT  = 1'b1;

    localparam logic [4:0] ORDER_RESET = 5'd4;
    localparam logic [4:0] ORDER_MIN   = 5'd2;
    localparam logic [4:0] ORDER_MAX   = 5'd16;
    localparam logic [2:0] COUNT_RESET = 3'd3;

    localparam logic [31:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_NEG_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_HI,
        ST_RD_LO,
        ST_SPAN,
        ST_LOAD,
        ST_CHECK,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

endpackage

FILE: hdl/bspline_control_point_derivative_unit.sv
`timescale 1ns / 1ps
// B-spline derivative control point unit: top level with knot store and serial divider.
// Depends on bcpd_pkg and bcpd_ram.
//
// Load the knot vector first with knot items (tuser = 0), then stream one row of
// control points (tuser = 1, tlast on the final point). Every point after the first
// yields (k-1)*(P[i]-P[i-1])/(knot[i+k-1]-knot[i]) per coordinate lane in signed
// Q16.16, truncated toward zero and saturated to 32 bits. A knot item and the first
// point of a row leave the block ready for the next item. Any other point makes two
// knot reads through the single RAM port, then uses one shared radix-2 restoring
// divider producing one quotient bit per cycle for each of the n active lanes in turn.
// A lane that overflows is caught before division and skips the divider, and a zero
// knot span skips the divider for all lanes. The finished result sits in an output
// register, so a stalled master side only delays the next point.
module bspline_control_point_derivative_unit #(
    parameter int MAX_KNOTS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] knot_index, [39:8] knot_value, [71:40] coord_0, [103:72] coord_1,
    // [135:104] coord_2, [167:136] coord_3
    input  logic [bcpd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] cmd
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] deriv_0, [63:32] deriv_1, [95:64] deriv_2, [127:96] deriv_3,
    // [135:128] out_index
    output logic [bcpd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [4:0]                        cfg_data
);

    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int NL = bcpd_pkg::NUM_LANES;
    localparam int CW = bcpd_pkg::COORD_W;
    localparam int OUT_TDATA_W_HI = bcpd_pkg::OUT_TDATA_W - 1;

    bcpd_pkg::state_t state_reg, state_next;

    logic [4:0]  order_reg;
    logic [2:0]  count_reg;
    logic [7:0]  cnt_reg, cnt_next;
    logic        m_valid_reg, m_valid_next;

    logic [CW-1:0] cur_reg  [NL];
    logic [CW-1:0] cur_next [NL];
    logic [CW-1:0] prev_reg  [NL];
    logic [CW-1:0] prev_next [NL];
    logic [CW-1:0] res_reg  [NL];
    logic [CW-1:0] res_next [NL];
    logic [CW-1:0] out_deriv_reg  [NL];
    logic [CW-1:0] out_deriv_next [NL];

    logic          last_reg, last_next;
    logic [31:0]   knot_hi_reg, knot_hi_next;
    logic [31:0]   em_reg, em_next;
    logic          den_neg_reg, den_neg_next;
    logic          span_zero_reg, span_zero_next;
    logic [1:0]    lane_reg, lane_next;
    logic          neg_reg, neg_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   low_reg, low_next;
    logic [4:0]    bit_cnt_reg, bit_cnt_next;
    logic          sat_reg, sat_next;
    logic [7:0]    out_index_reg, out_index_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic          out_last_reg, out_last_next;

    // FSM outputs
    logic          rd_hi_sel;
    logic          out_load;

    // Input unpacking
    logic [7:0]    in_knot_index;
    logic [31:0]   in_knot_value;
    logic [CW-1:0] in_coord [NL];
    logic          in_xfer;

    assign in_knot_index = s_axis_tdata[7:0];
    assign in_knot_value = s_axis_tdata[39:8];
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    for (genvar j = 0; j < NL; j++)
    begin : g_lanes
        assign in_coord[j]           = s_axis_tdata[40 + CW*j +: CW];
        assign m_axis_tdata[CW*j +: CW] = out_deriv_reg[j];
    end

    assign m_axis_tdata[OUT_TDATA_W_HI:CW*NL] = out_index_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tvalid = m_valid_reg;

    // Clamped configuration
    logic [4:0] k_eff;
    logic [3:0] scale;
    logic [2:0] n_eff;

    always_comb
    begin
        if (order_reg < bcpd_pkg::ORDER_MIN)
        begin
            k_eff = bcpd_pkg::ORDER_MIN;
        end
        else if (order_reg > bcpd_pkg::ORDER_MAX)
        begin
            k_eff = bcpd_pkg::ORDER_MAX;
        end
        else
        begin
            k_eff = order_reg;
        end

        if (count_reg == 3'd0)
        begin
            n_eff = 3'd1;
        end
        else if (count_reg > 3'(NL))
        begin
            n_eff = 3'(NL);
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    assign scale = 4'(k_eff - 5'd1);

    // Knot store
    logic [bcpd_pkg::KIDX_W-1:0] hi_idx, lo_idx, rd_idx;
    logic          hi_oob, lo_oob;
    logic          ram_we;
    logic [31:0]   ram_rdata;

    assign hi_idx = {1'b0, cnt_reg} + {4'b0, k_eff} - 9'd1;
    assign lo_idx = {1'b0, cnt_reg};
    assign hi_oob = {{(32-bcpd_pkg::KIDX_W){1'b0}}, hi_idx} >= 32'(MAX_KNOTS);
    assign lo_oob = {{(32-bcpd_pkg::KIDX_W){1'b0}}, lo_idx} >= 32'(MAX_KNOTS);
    assign rd_idx = rd_hi_sel ? hi_idx : lo_idx;
    assign ram_we = in_xfer && (s_axis_tuser == bcpd_pkg::CMD_KNOT)
                    && ({24'b0, in_knot_index} < 32'(MAX_KNOTS));

    bcpd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_KNOTS),
        .ADDR_W(AW)
    ) u_knot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(AW'(in_knot_index)),
        .wdata(in_knot_value),
        .raddr(AW'(rd_idx)),
        .rdata(ram_rdata)
    );

    // Datapath helpers
    logic [31:0] knot_lo;
    logic [32:0] den;
    logic [31:0] den_mag;
    logic [32:0] diff;
    logic [31:0] diff_mag;
    logic [35:0] prod;
    logic        check_sat;
    logic [32:0] shifted;
    logic [32:0] shifted_sub;
    logic        div_ge;
    logic        fix_sat;
    logic [31:0] fix_val;
    logic        lane_last;

    assign knot_lo  = lo_oob ? 32'd0 : ram_rdata;
    assign den      = {knot_hi_reg[31], knot_hi_reg} - {knot_lo[31], knot_lo};
    assign den_mag  = den[32] ? 32'(-den) : den[31:0];

    assign diff     = {cur_reg[lane_reg][31], cur_reg[lane_reg]}
                      - {prev_reg[lane_reg][31], prev_reg[lane_reg]};
    assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
    assign prod     = 36'(diff_mag) * 36'(scale);

    // quotient needs more than 32 bits when the top part already reaches the divisor
    assign check_sat   = rem_reg >= em_reg;
    assign shifted     = {rem_reg, low_reg[31]};
    assign shifted_sub = shifted - {1'b0, em_reg};
    assign div_ge      = shifted >= {1'b0, em_reg};

    assign fix_sat   = neg_reg ? (low_reg > bcpd_pkg::Q_NEG_MIN) : low_reg[31];
    assign fix_val   = fix_sat ? (neg_reg ? bcpd_pkg::Q_NEG_MIN : bcpd_pkg::Q_POS_MAX)
                               : (neg_reg ? 32'd0 - low_reg : low_reg);
    assign lane_last = (3'(lane_reg) + 3'd1) >= n_eff;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcpd_pkg::ST_IDLE:
            begin
                if (in_xfer && s_axis_tuser == bcpd_pkg::CMD_POINT && cnt_reg != 8'd0)
                begin
                    state_next = bcpd_pkg::ST_RD_HI;
                end
            end
            bcpd_pkg::ST_RD_HI: state_next = bcpd_pkg::ST_RD_LO;
            bcpd_pkg::ST_RD_LO: state_next = bcpd_pkg::ST_SPAN;
            bcpd_pkg::ST_SPAN:
            begin
                state_next = (den == 33'd0) ? bcpd_pkg::ST_DONE : bcpd_pkg::ST_LOAD;
            end
            bcpd_pkg::ST_LOAD: state_next = bcpd_pkg::ST_CHECK;
            bcpd_pkg::ST_CHECK:
            begin
                if (check_sat)
                begin
                    state_next = lane_last ? bcpd_pkg::ST_DONE : bcpd_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = bcpd_pkg::ST_DIV;
                end
            end
            bcpd_pkg::ST_DIV:
            begin
                if (bit_cnt_reg == 5'd0)
                begin
                    state_next = bcpd_pkg::ST_FIX;
                end
            end
            bcpd_pkg::ST_FIX:
            begin
                state_next = lane_last ? bcpd_pkg::ST_DONE : bcpd_pkg::ST_LOAD;
            end
            bcpd_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = bcpd_pkg::ST_IDLE;
                end
            end
            default: state_next = bcpd_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_hi_sel     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            bcpd_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            bcpd_pkg::ST_RD_HI: rd_hi_sel = 1'b1;
            bcpd_pkg::ST_DONE:  out_load = !m_valid_reg || m_axis_tready;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        res_next        = res_reg;
        out_deriv_next  = out_deriv_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        knot_hi_next    = knot_hi_reg;
        em_next         = em_reg;
        den_neg_next    = den_neg_reg;
        span_zero_next  = span_zero_reg;
        lane_next       = lane_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        low_next        = low_reg;
        bit_cnt_next    = bit_cnt_reg;
        sat_next        = sat_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            bcpd_pkg::ST_IDLE:
            begin
                if (in_xfer && s_axis_tuser == bcpd_pkg::CMD_POINT)
                begin
                    if (cnt_reg == 8'd0)
                    begin
                        // first point of a row only primes the history
                        prev_next = in_coord;
                        cnt_next  = s_axis_tlast ? 8'd0 : 8'd1;
                    end
                    else
                    begin
                        cur_next  = in_coord;
                        last_next = s_axis_tlast;
                    end
                end
            end
            bcpd_pkg::ST_RD_LO:
            begin
                knot_hi_next = hi_oob ? 32'd0 : ram_rdata;
            end
            bcpd_pkg::ST_SPAN:
            begin
                em_next        = den_mag;
                den_neg_next   = den[32];
                span_zero_next = (den == 33'd0);
                lane_next      = 2'd0;
                sat_next       = 1'b0;
                for (int j = 0; j < NL; j++)
                begin
                    res_next[j] = '0;
                end
            end
            bcpd_pkg::ST_LOAD:
            begin
                neg_next = diff[32] ^ den_neg_reg;
                rem_next = {12'b0, prod[35:16]};
                low_next = {prod[15:0], 16'b0};
            end
            bcpd_pkg::ST_CHECK:
            begin
                if (check_sat)
                begin
                    res_next[lane_reg] = neg_reg ? bcpd_pkg::Q_NEG_MIN : bcpd_pkg::Q_POS_MAX;
                    sat_next           = 1'b1;
                    lane_next          = lane_reg + 2'd1;
                end
                else
                begin
                    bit_cnt_next = 5'(CW - 1);
                end
            end
            bcpd_pkg::ST_DIV:
            begin
                rem_next     = div_ge ? shifted_sub[31:0] : shifted[31:0];
                low_next     = {low_reg[30:0], div_ge};
                bit_cnt_next = bit_cnt_reg - 5'd1;
            end
            bcpd_pkg::ST_FIX:
            begin
                res_next[lane_reg] = fix_val;
                sat_next           = sat_reg | fix_sat;
                lane_next          = lane_reg + 2'd1;
            end
            bcpd_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_deriv_next = res_reg;
                    out_index_next = cnt_reg - 8'd1;
                    out_last_next  = last_reg;
                    if (span_zero_reg)
                    begin
                        out_status_next = bcpd_pkg::STATUS_ZERO_SPAN;
                    end
                    else if (sat_reg)
                    begin
                        out_status_next = bcpd_pkg::STATUS_SAT;
                    end
                    else
                    begin
                        out_status_next = bcpd_pkg::STATUS_OK;
                    end
                    prev_next = cur_reg;
                    if (last_reg)
                    begin
                        cnt_next = 8'd0;
                    end
                    else if (cnt_reg != 8'hFF)
                    begin
                        cnt_next = cnt_reg + 8'd1;
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bcpd_pkg::ST_IDLE;
            cnt_reg     <= 8'd0;
            m_valid_reg <= 1'b0;
            order_reg   <= bcpd_pkg::ORDER_RESET;
            count_reg   <= bcpd_pkg::COUNT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bcpd_pkg::REG_SPLINE_ORDER: order_reg <= cfg_data;
                    bcpd_pkg::REG_COORD_COUNT:  count_reg <= cfg_data[2:0];
                    default:                    order_reg <= order_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        res_reg        <= res_next;
        out_deriv_reg  <= out_deriv_next;
        last_reg       <= last_next;
        knot_hi_reg    <= knot_hi_next;
        em_reg         <= em_next;
        den_neg_reg    <= den_neg_next;
        span_zero_reg  <= span_zero_next;
        lane_reg       <= lane_next;
        neg_reg        <= neg_next;
        rem_reg        <= rem_next;
        low_reg        <= low_next;
        bit_cnt_reg    <= bit_cnt_next;
        sat_reg        <= sat_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule

FILE: hdl/bcpd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcpd_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/bcpd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the B-spline derivative control point unit, bound to the top.
// Depends on bcpd_pkg and bspline_control_point_derivative_unit.
module bcpd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bcpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                       m_axis_tuser,
    input logic                             m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == bcpd_pkg::STATUS_OK
            || m_axis_tuser == bcpd_pkg::STATUS_ZERO_SPAN
            || m_axis_tuser == bcpd_pkg::STATUS_SAT))
        else $error("reserved status code");

    a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == bcpd_pkg::STATUS_ZERO_SPAN
            |-> m_axis_tdata[127:0] == 128'd0)
        else $error("zero span result carries nonzero lanes");

    a_sat_lane: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == bcpd_pkg::STATUS_SAT
            |-> (m_axis_tdata[31:0] == bcpd_pkg::Q_POS_MAX
              || m_axis_tdata[31:0] == bcpd_pkg::Q_NEG_MIN
              || m_axis_tdata[63:32] == bcpd_pkg::Q_POS_MAX
              || m_axis_tdata[63:32] == bcpd_pkg::Q_NEG_MIN
              || m_axis_tdata[95:64] == bcpd_pkg::Q_POS_MAX
              || m_axis_tdata[95:64] == bcpd_pkg::Q_NEG_MIN
              || m_axis_tdata[127:96] == bcpd_pkg::Q_POS_MAX
              || m_axis_tdata[127:96] == bcpd_pkg::Q_NEG_MIN))
        else $error("saturated status without a clamped lane");

    // a knot write never occupies the block past its transfer
    a_knot_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == bcpd_pkg::CMD_KNOT
            |=> s_axis_tready)
        else $error("not ready after knot transfer");

endmodule

bind bspline_control_point_derivative_unit bcpd_checker u_bcpd_checker (.*);
